// File: src/assert_macros.svh
// Assertion macros shared by the string-to-integer converter modules.
// Each macro expects the module's clock named clk and its reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define A2I_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define A2I_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never be true.
`define A2I_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/a2i_pkg.sv
// Shared types, constants and helpers for the string-to-integer converter.
// No dependencies; used by a2i_front, a2i_queue, a2i_back, ascii_to_integer_parser and the testbench.
`default_nettype none

package a2i_pkg;

    // Field widths fixed by the interface
    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 6;
    localparam int VALUE_W   = 64;
    localparam int OFFSET_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;

    // Defaults for top-level parameters
    localparam int A2I_WIDTH       = 64;
    localparam int A2I_MAX_LEN     = 4096;
    localparam int A2I_QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED = 1'b1;

    // Register reset values
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Bases with special meaning
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

    // Digit value of a character that is no digit in any base
    localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;
    localparam logic [RADIX_W-1:0] DIGIT_ALPHA = 6'd10;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;

    // Character classes the front end hands to the back end
    typedef enum logic [2:0] {
        CLS_SPACE = 3'd0,
        CLS_PLUS  = 3'd1,
        CLS_MINUS = 3'd2,
        CLS_ZERO  = 3'd3,
        CLS_X     = 3'd4,
        CLS_OTHER = 3'd5
    } char_class_t;

    // One classified character
    typedef struct packed {
        char_class_t          cls;
        logic [RADIX_W-1:0]   digit;
        logic                 first;
        logic                 last;
    } char_info_t;

    // Parse phases, one-hot
    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    // Base 1 and anything above 36 are invalid
    function automatic logic radix_bad(input logic [RADIX_W-1:0] b);
        return (b == RADIX_ONE) || (b > RADIX_MAX);
    endfunction

endpackage

`default_nettype wire

// File: src/a2i_front.sv
// Front end: classifies each accepted character and marks the first of a string.
// Depends on a2i_pkg.
`default_nettype none

module a2i_front
    import a2i_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              last_char,
    output char_info_t             info
);

    logic                first_reg;
    logic                first_next;
    logic [CHAR_W-1:0]   diff;
    char_class_t         cls;
    logic [RADIX_W-1:0]  digit;

    // Track start of string: the beat after a last character opens a new one
    always_comb
    begin
        first_next = first_reg;
        if (accept)
        begin
            first_next = last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

    // Classify the character
    always_comb
    begin
        if (char_code == CHAR_SPACE || (char_code inside {[CHAR_TAB:CHAR_CR]}))
        begin
            cls = CLS_SPACE;
        end
        else if (char_code == CHAR_PLUS)
        begin
            cls = CLS_PLUS;
        end
        else if (char_code == CHAR_MINUS)
        begin
            cls = CLS_MINUS;
        end
        else if (char_code == CHAR_0)
        begin
            cls = CLS_ZERO;
        end
        else if (char_code == CHAR_LX || char_code == CHAR_UX)
        begin
            cls = CLS_X;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    // Decode digit value in base 36
    always_comb
    begin
        diff  = '0;
        digit = DIGIT_NONE;
        if (char_code inside {[CHAR_0:CHAR_9]})
        begin
            diff  = char_code - CHAR_0;
            digit = diff[RADIX_W-1:0];
        end
        else if (char_code inside {[CHAR_LA:CHAR_LZ]})
        begin
            diff  = char_code - CHAR_LA;
            digit = diff[RADIX_W-1:0] + DIGIT_ALPHA;
        end
        else if (char_code inside {[CHAR_UA:CHAR_UZ]})
        begin
            diff  = char_code - CHAR_UA;
            digit = diff[RADIX_W-1:0] + DIGIT_ALPHA;
        end
    end

    assign info.cls   = cls;
    assign info.digit = digit;
    assign info.first = first_reg;
    assign info.last  = last_char;

endmodule

`default_nettype wire

// File: src/a2i_queue.sv
// Short FIFO between the front end and the back end.
// Depends on a2i_pkg for the default of DEPTH and on assert_macros.svh; DATA_W and DEPTH set its size.
`default_nettype none
`include "assert_macros.svh"

module a2i_queue
    import a2i_pkg::*;
#(
    parameter int DATA_W = 10,
    parameter int DEPTH  = A2I_QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   nonempty,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `A2I_ASSERT_NEVER(a_no_push_full, push && full, "queue pushed while full")
    `A2I_ASSERT_NEVER(a_no_pop_empty, pop && !nonempty, "queue popped while empty")
    `A2I_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not grow on push")

endmodule

`default_nettype wire

// File: src/a2i_back.sv
// Back end: parse state machine, multiply-accumulate with saturation, result register.
// Depends on a2i_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module a2i_back
    import a2i_pkg::*;
#(
    parameter int WIDTH   = A2I_WIDTH,
    parameter int MAX_LEN = A2I_MAX_LEN
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [RADIX_W-1:0]  radix,
    input  wire logic                signed_mode,
    input  wire logic                q_valid,
    input  char_info_t               q_info,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [VALUE_W-1:0]       value,
    output logic [OFFSET_W-1:0]      end_offset,
    output logic                     overflowed,
    output logic                     bad_radix
);

    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = WIDTH + RADIX_W;
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_LEN);
    localparam logic [WIDTH-1:0] ALL_ONES = '1;
    localparam logic [WIDTH-1:0] POS_LIM  = ALL_ONES >> 1;
    localparam logic [WIDTH-1:0] NEG_LIM  = POS_LIM + 1'b1;

    // Per-string parse state
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [WIDTH-1:0]    mag_reg;
    logic [WIDTH-1:0]    mag_next;
    logic                neg_reg;
    logic                neg_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [RADIX_W-1:0]  base_reg;
    logic [RADIX_W-1:0]  base_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    end_reg;
    logic [POS_W-1:0]    end_next;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                ovf_out_reg;
    logic                bad_reg;

    // Step working values
    phase_t              ph_eff;
    phase_t              ph_treat;
    logic [RADIX_W-1:0]  base_d;
    logic [POS_W-1:0]    newpos;
    logic                take;
    logic [WIDTH-1:0]    lim;
    logic [PROD_W-1:0]   prod;
    logic                bad_now;
    logic [WIDTH-1:0]    v_res;
    logic [VALUE_W+WIDTH-1:0] v_wide;
    logic [OFFSET_W+POS_W-1:0] end_wide;
    logic                step;

    // Take a beat unless it is a last character and the result slot is held
    assign q_pop = q_valid && (!q_info.last || !out_valid_reg || !out_stall);
    assign step  = q_pop;

    assign newpos = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // Parse one character
    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        end_next   = end_reg;
        base_next  = q_info.first ? radix : base_reg;
        ph_eff     = (q_info.first && radix_bad(radix)) ? PH_DONE : phase_reg;
        if (q_info.first && radix_bad(radix))
        begin
            phase_next = PH_DONE;
        end
        ph_treat   = ph_eff;
        take       = 1'b0;

        // Skip whitespace, take one sign, else handle the character as a digit
        if (ph_eff == PH_SPACE)
        begin
            case (q_info.cls)
                CLS_SPACE:
                begin
                end
                CLS_PLUS:
                begin
                    phase_next = PH_SIGNED;
                end
                CLS_MINUS:
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGNED;
                end
                default:
                begin
                    ph_treat = PH_SIGNED;
                end
            endcase
        end

        base_d = base_next;
        case (ph_treat)
            PH_SIGNED:
            begin
                if ((base_next == RADIX_AUTO || base_next == RADIX_HEX)
                    && q_info.cls == CLS_ZERO)
                begin
                    mag_next   = '0;
                    end_next   = newpos;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_d    = (base_next == RADIX_AUTO) ? RADIX_DEC : base_next;
                    base_next = base_d;
                    take      = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (q_info.cls == CLS_X)
                begin
                    base_next  = RADIX_HEX;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    base_d    = (base_next == RADIX_AUTO) ? RADIX_OCT : base_next;
                    base_next = base_d;
                    take      = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Accumulate one digit, saturating at the limit of the sign and mode
        if (!signed_mode)
        begin
            lim = ALL_ONES;
        end
        else
        begin
            lim = neg_reg ? NEG_LIM : POS_LIM;
        end
        prod = ({{RADIX_W{1'b0}}, mag_reg} * {{WIDTH{1'b0}}, base_d})
             + {{WIDTH{1'b0}}, q_info.digit};
        if (take)
        begin
            if (q_info.digit >= base_d)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_DIGITS;
                end_next   = newpos;
                if (!ovf_reg)
                begin
                    if (prod > {{RADIX_W{1'b0}}, lim})
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = prod[WIDTH-1:0];
                    end
                end
            end
        end
        pos_next = newpos;
    end

    // Form the result from the state after this character
    always_comb
    begin
        bad_now = radix_bad(base_next);
        if (bad_now)
        begin
            v_res = '0;
        end
        else if (ovf_next)
        begin
            if (!signed_mode)
            begin
                v_res = ALL_ONES;
            end
            else
            begin
                v_res = neg_next ? NEG_LIM : POS_LIM;
            end
        end
        else
        begin
            v_res = neg_next ? ('0 - mag_next) : mag_next;
        end
        v_wide   = {{VALUE_W{1'b0}}, v_res};
        end_wide = {{OFFSET_W{1'b0}}, end_next};
    end

    // Hold or drop the result beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && q_info.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            base_reg      <= '0;
            pos_reg       <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                if (q_info.last)
                begin
                    phase_reg <= PH_SPACE;
                    mag_reg   <= '0;
                    neg_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                    base_reg  <= '0;
                    pos_reg   <= '0;
                    end_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    mag_reg   <= mag_next;
                    neg_reg   <= neg_next;
                    ovf_reg   <= ovf_next;
                    base_reg  <= base_next;
                    pos_reg   <= pos_next;
                    end_reg   <= end_next;
                end
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (step && q_info.last)
        begin
            value_reg   <= v_wide[VALUE_W-1:0];
            offset_reg  <= bad_now ? '0 : end_wide[OFFSET_W-1:0];
            ovf_out_reg <= !bad_now && ovf_next;
            bad_reg     <= bad_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_offset = offset_reg;
    assign overflowed = ovf_out_reg;
    assign bad_radix  = bad_reg;

    `A2I_ASSERT_NEXT(a_clear_after_last, step && q_info.last,
        phase_reg == PH_SPACE && pos_reg == '0 && !ovf_reg,
        "parse state not cleared after last character")
    `A2I_ASSERT_IMPL(a_ovf_in_digits, ovf_reg,
        phase_reg == PH_DIGITS || phase_reg == PH_DONE,
        "overflow flagged outside digit phase")
    `A2I_ASSERT_IMPL(a_bad_gives_zero, out_valid_reg && bad_reg,
        value_reg == '0 && offset_reg == '0 && !ovf_out_reg,
        "invalid base result not zero")

endmodule

`default_nettype wire

// File: src/ascii_to_integer_parser.sv
// Top level of the streaming string-to-integer converter: config registers,
// front end, queue and back end. Depends on a2i_pkg, a2i_front, a2i_queue, a2i_back.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  char_code, last_char
//  result    out        out_valid/out_stall  value, end_offset, overflowed, bad_radix
//  config    in         cfg_wr_en            cfg_index, cfg_data
//
// One character per cycle sustained while in_stall is low; the back end's
// multiply-by-base, add and limit compare on the magnitude is combinational and
// sets that rate. out_valid is registered when the back end pops a last character.
// in_stall rises only when the queue is full; the queue fills only while a
// result waits on out_stall and a further last character is at its head.
// Reset is asynchronous, active low; no clearing pass follows it.
`default_nettype none

module ascii_to_integer_parser
    import a2i_pkg::*;
#(
    parameter int WIDTH       = A2I_WIDTH,
    parameter int MAX_LEN     = A2I_MAX_LEN,
    parameter int QUEUE_DEPTH = A2I_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CHAR_W-1:0]    char_code,
    input  wire logic                 last_char,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [VALUE_W-1:0]        value,
    output logic [OFFSET_W-1:0]       end_offset,
    output logic                      overflowed,
    output logic                      bad_radix
);

    localparam int INFO_W = $bits(char_info_t);

    logic [RADIX_W-1:0] radix_reg;
    logic               signed_mode_reg;
    logic               push;
    logic               q_full;
    logic               q_nonempty;
    logic               q_pop;
    char_info_t         front_info;
    char_info_t         q_info;
    logic [INFO_W-1:0]  q_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_RADIX:
                begin
                    radix_reg <= cfg_data[RADIX_W-1:0];
                end
                CFG_IDX_SIGNED:
                begin
                    signed_mode_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Accept a character whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    a2i_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push),
        .char_code (char_code),
        .last_char (last_char),
        .info      (front_info)
    );

    a2i_queue #(
        .DATA_W (INFO_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_info),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (q_data)
    );

    assign q_info = char_info_t'(q_data);

    a2i_back #(
        .WIDTH   (WIDTH),
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix       (radix_reg),
        .signed_mode (signed_mode_reg),
        .q_valid     (q_nonempty),
        .q_info      (q_info),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .end_offset  (end_offset),
        .overflowed  (overflowed),
        .bad_radix   (bad_radix)
    );

endmodule

`default_nettype wire

// File: tb/tb_ascii_to_integer_parser.sv
// Testbench for ascii_to_integer_parser: streams strings one character per beat,
// predicts each number in place or takes a typed one; checks every result beat.
// Depends on a2i_pkg and the ascii_to_integer_parser RTL.
`timescale 1ns / 1ps

module tb_ascii_to_integer_parser;
    import a2i_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          RANDOM_CHARS   = 1300;
    localparam logic [7:0]  ZERO_BYTE      = 8'h00;
    localparam int          NOT_DIGIT      = 99;
    localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OVER = 6'd37;
    localparam logic [RADIX_W-1:0] RADIX_TOP  = 6'd63;
    localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SMIN = {1'b1, 63'b0};
    localparam logic [63:0] UMAX = {64{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
        logic                ovf;
        logic                bad;
    } number_t;

    typedef struct {
        logic [RADIX_W-1:0] radix;
        bit                 sgn;
        string              text;
        int                 zero_at;
        bit                 typed;
        number_t            want;
    } case_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_RADIX;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    char_code = '0;
    logic                 last_char = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [VALUE_W-1:0]   value;
    logic [OFFSET_W-1:0]  end_offset;
    logic                 overflowed;
    logic                 bad_radix;

    // Shadow of the configuration registers
    logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
    bit                 signed_reg = 1'b1;

    // Running state of the string being parsed
    logic [63:0]        acc_mag;
    phase_t             acc_phase;
    bit                 acc_neg;
    bit                 acc_ovf;
    logic [RADIX_W-1:0] acc_base;
    int unsigned        acc_pos;
    int unsigned        acc_end;

    number_t     parsed_numbers[$];
    case_row_t   dir_rows[$];
    logic [7:0]  str_buf[$];
    bit          use_typed;
    number_t     typed_want;

    int burst_left;
    int errors, strings_sent, chars_sent, rand_chars, numbers_checked;
    int sat_count, bad_count, in_stall_cycles, cfg_writes, idle_cycles;
    bit hold_off_req, hold_off_done;
    int hold_left, stall_mode, mode_left;

    ascii_to_integer_parser uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .end_offset (end_offset),
        .overflowed (overflowed),
        .bad_radix  (bad_radix)
    );

    always #5 clk = ~clk;

    function automatic int digit_of(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9)
            return int'(c - CHAR_0);
        if (c >= CHAR_LA && c <= CHAR_LZ)
            return 10 + int'(c - CHAR_LA);
        if (c >= CHAR_UA && c <= CHAR_UZ)
            return 10 + int'(c - CHAR_UA);
        return NOT_DIGIT;
    endfunction

    function automatic number_t mk_num(input logic [63:0] v, input int off,
                                       input bit ovf, input bit bad);
        number_t n;
        n.value  = v;
        n.offset = OFFSET_W'(off);
        n.ovf    = ovf;
        n.bad    = bad;
        return n;
    endfunction

    function automatic void add_row(input logic [RADIX_W-1:0] radix, input bit sgn,
                                    input string text, input int zero_at,
                                    input bit typed, input number_t want);
        case_row_t r;
        r.radix   = radix;
        r.sgn     = sgn;
        r.text    = text;
        r.zero_at = zero_at;
        r.typed   = typed;
        r.want    = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void restart_string();
        acc_mag   = '0;
        acc_phase = PH_SPACE;
        acc_neg   = 1'b0;
        acc_ovf   = 1'b0;
        acc_base  = RADIX_AUTO;
        acc_pos   = 0;
        acc_end   = 0;
    endfunction

    // Accumulate one digit, or end the number if it does not fit the base
    task automatic take_digit(input logic [7:0] c, input int unsigned np);
        int          d;
        logic [63:0] lim, q, r, b;
        d = digit_of(c);
        if (d >= int'(acc_base))
        begin
            acc_phase = PH_DONE;
        end
        else
        begin
            acc_phase = PH_DIGITS;
            acc_end   = np;
            if (!acc_ovf)
            begin
                if (!signed_reg)
                    lim = UMAX;
                else
                    lim = acc_neg ? SMIN : SMAX;
                b = 64'(acc_base);
                q = lim / b;
                r = lim % b;
                if (acc_mag > q || (acc_mag == q && 64'(d) > r))
                    acc_ovf = 1'b1;
                else
                    acc_mag = acc_mag * b + 64'(d);
            end
        end
    endtask

    // Advance the parse by one accepted character; on the last one queue the number
    task automatic parse_char(input logic [7:0] c, input bit fin);
        int unsigned np;
        bit          skip;
        bit          bad;
        number_t     res;
        np   = (acc_pos + 1 > A2I_MAX_LEN) ? A2I_MAX_LEN : acc_pos + 1;
        skip = 1'b0;
        if (acc_pos == 0 && acc_phase == PH_SPACE)
        begin
            acc_base = radix_reg;
            if (acc_base == RADIX_ONE || acc_base > RADIX_MAX)
                acc_phase = PH_DONE;
        end
        if (acc_phase == PH_SPACE)
        begin
            skip = 1'b1;
            if (c == CHAR_PLUS)
            begin
                acc_phase = PH_SIGNED;
            end
            else if (c == CHAR_MINUS)
            begin
                acc_neg   = 1'b1;
                acc_phase = PH_SIGNED;
            end
            else if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)))
            begin
                acc_phase = PH_SIGNED;
                skip      = 1'b0;
            end
        end
        if (!skip)
        begin
            if (acc_phase == PH_SIGNED)
            begin
                if ((acc_base == RADIX_AUTO || acc_base == RADIX_HEX) && c == CHAR_0)
                begin
                    acc_mag   = '0;
                    acc_end   = np;
                    acc_phase = PH_ZERO;
                end
                else
                begin
                    if (acc_base == RADIX_AUTO)
                        acc_base = RADIX_DEC;
                    take_digit(c, np);
                end
            end
            else if (acc_phase == PH_ZERO)
            begin
                if (c == CHAR_LX || c == CHAR_UX)
                begin
                    acc_base  = RADIX_HEX;
                    acc_phase = PH_DIGITS;
                end
                else
                begin
                    if (acc_base == RADIX_AUTO)
                        acc_base = RADIX_OCT;
                    take_digit(c, np);
                end
            end
            else if (acc_phase == PH_DIGITS)
            begin
                take_digit(c, np);
            end
        end
        acc_pos = np;
        if (fin)
        begin
            bad = (acc_base == RADIX_ONE || acc_base > RADIX_MAX);
            if (bad)
                res.value = '0;
            else if (acc_ovf)
                res.value = signed_reg ? (acc_neg ? SMIN : SMAX) : UMAX;
            else
                res.value = acc_neg ? -acc_mag : acc_mag;
            res.offset = bad ? '0 : OFFSET_W'(acc_end);
            res.ovf    = !bad && acc_ovf;
            res.bad    = bad;
            parsed_numbers.push_back(use_typed ? typed_want : res);
            use_typed = 1'b0;
            restart_string();
        end
    endtask

    // Offer one character beat, with bursts and random gaps in between
    task automatic send_beat(input logic [7:0] c, input bit fin);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= fin;
        do
            @(posedge clk);
        while (in_stall);
        parse_char(c, fin);
        chars_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_buf.size(); i++)
            send_beat(str_buf[i], i == str_buf.size() - 1);
        strings_sent++;
    endtask

    // Drop valid and wait until every queued number has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (parsed_numbers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_IDX_RADIX)
            radix_reg = data;
        else
            signed_reg = data[0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [RADIX_W-1:0] pick_radix();
        case ($urandom_range(0, 7))
            0: return RADIX_AUTO;
            1: return RADIX_BIN;
            2: return RADIX_OCT;
            3: return RADIX_DEC;
            4: return RADIX_HEX;
            5: return RADIX_MAX;
            6: return RADIX_ONE;
            default: return RADIX_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [7:0] ws_char();
        int r;
        r = $urandom_range(0, 6);
        return (r > 4) ? CHAR_SPACE : CHAR_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10)
            return CHAR_0 + 8'(d);
        return (upper ? CHAR_UA : CHAR_LA) + 8'(d - 10);
    endfunction

    // Mostly well-formed numbers with random content, some pure noise
    task automatic fill_random_string();
        int n, b, d;
        str_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3)) str_buf.push_back(ws_char());
            case ($urandom_range(0, 3))
                1: str_buf.push_back(CHAR_PLUS);
                2: str_buf.push_back(CHAR_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 7) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        str_buf.push_back(CHAR_0);
                        str_buf.push_back(CHAR_LX);
                    end
                    1:
                    begin
                        str_buf.push_back(CHAR_0);
                        str_buf.push_back(CHAR_UX);
                    end
                    2: str_buf.push_back(CHAR_0);
                    default: ;
                endcase
                b = int'(radix_reg);
                if (b < 2 || b > 36)
                    b = 16;
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
                repeat (n)
                begin
                    d = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 35)
                                                     : $urandom_range(0, b - 1);
                    str_buf.push_back(digit_char(d, 1'($urandom_range(0, 1))));
                end
            end
            case ($urandom_range(0, 5))
                0: str_buf.push_back(8'($urandom_range(0, 255)));
                1:
                begin
                    str_buf.push_back(ZERO_BYTE);
                    str_buf.push_back(digit_char($urandom_range(0, 9), 1'b0));
                end
                default: ;
            endcase
        end
        if (str_buf.size() == 0)
            str_buf.push_back(CHAR_SPACE);
    endtask

    // Stall the result channel on a pattern of its own, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_off_req && !hold_off_done)
        begin
            hold_left     = 400;
            hold_off_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(5, 60);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Check each result beat against the oldest queued number
    always @(posedge clk)
    begin
        number_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (parsed_numbers.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing queued: value %h offset %0d",
                         $time, value, end_offset);
            end
            else
            begin
                want = parsed_numbers.pop_front();
                numbers_checked++;
                if (overflowed) sat_count++;
                if (bad_radix) bad_count++;
                if (value !== want.value)
                begin
                    errors++;
                    $display("%0t: value mismatch: expected %h, got %h",
                             $time, want.value, value);
                end
                if (end_offset !== want.offset)
                begin
                    errors++;
                    $display("%0t: end_offset mismatch: expected %0d, got %0d",
                             $time, want.offset, end_offset);
                end
                if (overflowed !== want.ovf)
                begin
                    errors++;
                    $display("%0t: overflowed mismatch: expected %b, got %b",
                             $time, want.ovf, overflowed);
                end
                if (bad_radix !== want.bad)
                begin
                    errors++;
                    $display("%0t: bad_radix mismatch: expected %b, got %b",
                             $time, want.bad, bad_radix);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_stall_cycles++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d numbers still queued", $time,
                         parsed_numbers.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        case_row_t row;
        restart_string();

        // Directed cases: extremes, prefixes, signs, bad bases
        add_row(RADIX_DEC, 1, "7", -1, 1, mk_num(64'd7, 1, 0, 0));
        add_row(RADIX_DEC, 1, " \t\n\v\f\r-42x", -1, 0, '0);
        add_row(RADIX_DEC, 1, " +", -1, 1, mk_num('0, 0, 0, 0));
        add_row(RADIX_DEC, 1, "3_9", 1, 0, '0);
        add_row(RADIX_DEC, 1, "12a34", -1, 0, '0);
        add_row(RADIX_DEC, 1, "\x80\x7f1", -1, 1, mk_num('0, 0, 0, 0));
        add_row(RADIX_AUTO, 1, "0x1fZ", -1, 0, '0);
        add_row(RADIX_AUTO, 1, "0xg", -1, 1, mk_num('0, 1, 0, 0));
        add_row(RADIX_AUTO, 1, "-017", -1, 0, '0);
        add_row(RADIX_AUTO, 1, "09", -1, 1, mk_num('0, 1, 0, 0));
        add_row(RADIX_AUTO, 1, "42", -1, 0, '0);
        add_row(RADIX_HEX, 1, "0XfF", -1, 0, '0);
        add_row(RADIX_HEX, 1, "7fffffffffffffff", -1, 1, mk_num(SMAX, 16, 0, 0));
        add_row(RADIX_HEX, 1, "-8000000000000000", -1, 1, mk_num(SMIN, 17, 0, 0));
        add_row(RADIX_MAX, 1, "zzzzzzzzzzzzz", -1, 1, mk_num(SMAX, 13, 1, 0));
        add_row(RADIX_MAX, 1, "-ZZZZZZZZZZZZZ", -1, 1, mk_num(SMIN, 14, 1, 0));
        add_row(RADIX_HEX, 0, "ffffffffffffffff", -1, 1, mk_num(UMAX, 16, 0, 0));
        add_row(RADIX_MAX, 0, "zzzzzzzzzzzzz1", -1, 1, mk_num(UMAX, 14, 1, 0));
        add_row(RADIX_BIN, 0, "-1", -1, 1, mk_num(UMAX, 2, 0, 0));
        add_row(RADIX_OCT, 0, "\xff", -1, 1, mk_num('0, 0, 0, 0));
        add_row(RADIX_ONE, 1, "12", -1, 1, mk_num('0, 0, 0, 1));
        add_row(RADIX_TOP, 1, "5", -1, 1, mk_num('0, 0, 0, 1));
        add_row(RADIX_OVER, 0, "-9", -1, 1, mk_num('0, 0, 0, 1));

        // Hold reset, then release it at a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.radix != radix_reg || row.sgn != signed_reg)
            begin
                drain();
                write_reg(CFG_IDX_RADIX, row.radix);
                write_reg(CFG_IDX_SIGNED, {5'($urandom_range(0, 31)), row.sgn});
            end
            str_buf.delete();
            for (int k = 0; k < row.text.len(); k++)
                str_buf.push_back((k == row.zero_at) ? ZERO_BYTE : row.text[k]);
            use_typed  = row.typed;
            typed_want = row.want;
            send_string();
        end

        // Random strings, with a new setting every 20 strings
        for (int s = 0; rand_chars < RANDOM_CHARS; s++)
        begin
            if (s % 20 == 0)
            begin
                drain();
                write_reg(CFG_IDX_RADIX, pick_radix());
                write_reg(CFG_IDX_SIGNED, CFG_W'($urandom_range(0, 63)));
            end
            if (s == 60)
                hold_off_req = 1'b1;
            fill_random_string();
            rand_chars += str_buf.size();
            send_string();
        end

        drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d strings (%0d characters) over %0d register writes;",
                 strings_sent, chars_sent, cfg_writes);
        $display("checked %0d numbers, %0d saturated, %0d bad radix, %0d input stall cycles.",
                 numbers_checked, sat_count, bad_count, in_stall_cycles);
        if (errors == 0 && parsed_numbers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
